>>> hw/rtl/tle_pkg.sv
// Package for the terminal line editor: line store depth, control key codes
// and register map constants. Has no dependencies.
package tle_pkg;

   // Default depth of the line store
   localparam int LINE_DEPTH = 32;

   // Control keys recognized in cooked mode
   localparam logic [7:0] KEY_EOF  = 8'h04;
   localparam logic [7:0] KEY_INTR = 8'h03;
   localparam logic [7:0] KEY_BS   = 8'h08;
   localparam logic [7:0] KEY_CR   = 8'h0D;
   localparam logic [7:0] KEY_NL   = 8'h0A;

   // Result destinations
   localparam logic DEST_ECHO   = 1'b0;
   localparam logic DEST_READER = 1'b1;

   // Register map: word index taken from paddr[2]
   localparam int         CSR_ADDR_W     = 3;
   localparam int         CSR_DATA_W     = 32;
   localparam logic [0:0] CSR_COOKED_MODE = 1'b0;

endpackage

>>> hw/rtl/tty_line_editor_unit.sv
// Terminal line editor: raw pass-through or cooked echo and line editing.
// Depends on tle_pkg and tle_ram.
// The first result of a request is registered in the cycle after accept.
// Requests stall while a flush or newline tail runs or the result is held; a flush reads
// the line store, then delivers each stored byte, then a trailing newline if one is due.
// Reset: synchronous; empties the line, sets cooked mode; store is not cleared.
module tty_line_editor_unit #(
   parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_dest,
   output logic [7:0]                      rsp_data,
   output logic                            rsp_end_of_file,
   output logic                            rsp_last,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tle_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tle_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tle_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_TAIL
   } state_type;

   state_type        state_ff, state_in;
   logic             cooked_ff, cooked_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             primed_ff, primed_in;
   logic             has_tail_ff, has_tail_in;
   logic             tail_eof_ff, tail_eof_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_dest_ff, rsp_dest_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_eof_ff, rsp_eof_in;
   logic             rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              accept;
   logic              full;
   logic              flush_last;
   logic              csr_wr;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // Line store
   tle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == FULL);

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == tle_pkg::CSR_COOKED_MODE) ?
                   {{(tle_pkg::CSR_DATA_W-1){1'b0}}, cooked_ff} : '0;

   always_comb begin
      cooked_in = cooked_ff;
      if (csr_wr && (paddr[2] == tle_pkg::CSR_COOKED_MODE)) begin
         cooked_in = pwdata[0];
      end
   end

   // Editing and flush sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      has_tail_in  = has_tail_ff;
      tail_eof_in  = tail_eof_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dest_in  = rsp_dest_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_eof_in   = rsp_eof_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_addr      = rd_idx_ff[ADDR_W-1:0];
      flush_last   = (CNT_W'(rd_idx_ff + 1'b1) == fill_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = req_rx_byte;
               rsp_eof_in   = 1'b0;
               rsp_last_in  = 1'b1;
               rd_idx_in    = '0;
               if (!cooked_ff) begin
                  rsp_dest_in = tle_pkg::DEST_READER;
               end else begin
                  rsp_dest_in = tle_pkg::DEST_ECHO;
                  case (req_rx_byte)
                     tle_pkg::KEY_EOF: begin
                        rsp_last_in = 1'b0;
                        if (fill_ff == '0) begin
                           tail_eof_in = 1'b1;
                           state_in    = ST_TAIL;
                        end else begin
                           has_tail_in = 1'b0;
                           state_in    = ST_FLUSH;
                        end
                     end
                     tle_pkg::KEY_INTR: begin
                        // discard the line, deliver a lone newline
                        rsp_last_in = 1'b0;
                        fill_in     = '0;
                        tail_eof_in = 1'b0;
                        state_in    = ST_TAIL;
                     end
                     tle_pkg::KEY_BS: begin
                        if (fill_ff != '0) begin
                           fill_in = CNT_W'(fill_ff - 1'b1);
                        end
                     end
                     tle_pkg::KEY_CR: begin
                     end
                     tle_pkg::KEY_NL: begin
                        // newline goes out after the stored bytes, if it fits
                        rsp_last_in = 1'b0;
                        tail_eof_in = 1'b0;
                        if (fill_ff == '0) begin
                           state_in = ST_TAIL;
                        end else begin
                           has_tail_in = !full;
                           state_in    = ST_FLUSH;
                        end
                     end
                     default: begin
                        if (!full) begin
                           wr_en   = 1'b1;
                           fill_in = CNT_W'(fill_ff + 1'b1);
                        end
                     end
                  endcase
               end
            end
         end
         ST_FLUSH: begin
            // read data matches rd_idx once primed; next address issued on load
            if (primed_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dest_in  = tle_pkg::DEST_READER;
               rsp_data_in  = rd_data;
               rsp_eof_in   = 1'b0;
               rsp_last_in  = flush_last && !has_tail_ff;
               if (flush_last) begin
                  fill_in  = '0;
                  state_in = has_tail_ff ? ST_TAIL : ST_IDLE;
               end else begin
                  rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
                  rd_addr   = rd_idx_in[ADDR_W-1:0];
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dest_in  = tle_pkg::DEST_READER;
               rsp_data_in  = tail_eof_ff ? 8'h00 : tle_pkg::KEY_NL;
               rsp_eof_in   = tail_eof_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      primed_in = (state_ff == ST_FLUSH) && (state_in == ST_FLUSH);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cooked_ff    <= 1'b1;
         fill_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cooked_ff    <= cooked_in;
         fill_ff      <= fill_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      has_tail_ff <= has_tail_in;
      tail_eof_ff <= tail_eof_in;
      rsp_dest_ff <= rsp_dest_in;
      rsp_data_ff <= rsp_data_in;
      rsp_eof_ff  <= rsp_eof_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest        = rsp_dest_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_end_of_file = rsp_eof_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> hw/rtl/tle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/tb.sv
// Testbench for tty_line_editor_unit: an in-bench line editor model predicts every
// echo and delivery; directed, back-pressure and random traffic tests run in turn.
// Depends on tle_pkg and the RTL of tty_line_editor_unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tle_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = LINE_DEPTH + 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_COOKED = CSR_ADDR_W'(4 * CSR_COOKED_MODE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = ADDR_COOKED + CSR_ADDR_W'(4);

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       end_of_file;
      logic       last;
   } result_type;

   // DUT signals
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_dest;
   logic [7:0] rsp_data;
   logic rsp_end_of_file;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // Model state of the editor
   logic [7:0] line_copy [LINE_DEPTH];
   int         line_fill = 0;
   logic       cooked_copy = 1'b1;
   result_type due_results [$];

   // Bench control
   int   error_count = 0;
   int   quiet_cycles = 0;
   bit   idle_on = 1'b0;
   int   hold_left = 0;
   int   burst_left = 0;
   bit   burst_stall = 1'b0;

   tty_line_editor_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest        (rsp_dest),
      .rsp_data        (rsp_data),
      .rsp_end_of_file (rsp_end_of_file),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic result_type make_result(input logic dest, input logic [7:0] data,
                                              input logic eof);
      result_type r;
      r.dest = dest;
      r.data = data;
      r.end_of_file = eof;
      r.last = 1'b0;
      return r;
   endfunction

   // Append a byte to the model line; dropped when the line is full
   function automatic void store_in_line(input logic [7:0] b);
      if (line_fill < LINE_DEPTH) begin
         line_copy[line_fill] = b;
         line_fill++;
      end
   endfunction

   // Work out the results one accepted request causes and queue them
   function automatic void predict_editor_output(input logic [7:0] b);
      result_type due [$];
      result_type tail;
      bit         deliver;
      deliver = 1'b0;
      if (!cooked_copy) begin
         due.push_back(make_result(DEST_READER, b, 1'b0));
      end else begin
         due.push_back(make_result(DEST_ECHO, b, 1'b0));
         case (b)
            KEY_EOF: begin
               if (line_fill == 0) due.push_back(make_result(DEST_READER, 8'h00, 1'b1));
               else deliver = 1'b1;
            end
            KEY_INTR: begin
               line_fill = 0;
               store_in_line(KEY_NL);
               deliver = 1'b1;
            end
            KEY_BS: begin
               if (line_fill > 0) line_fill--;
            end
            KEY_CR: ;
            KEY_NL: begin
               store_in_line(KEY_NL);
               deliver = 1'b1;
            end
            default: store_in_line(b);
         endcase
         if (deliver) begin
            for (int i = 0; i < line_fill; i++)
               due.push_back(make_result(DEST_READER, line_copy[i], 1'b0));
            line_fill = 0;
         end
      end
      tail = due[due.size() - 1];
      tail.last = 1'b1;
      due[due.size() - 1] = tail;
      foreach (due[i]) due_results.push_back(due[i]);
   endfunction

   // Offer one request; entered and left at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_editor_output(b);
      @(negedge clock);
   endtask

   // Stop offering, let every expected result arrive, then let the block settle
   task automatic wait_line_idle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_COOKED) cooked_copy = value[0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_mode_readback();
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(cooked_copy);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_COOKED;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want)
         report_mismatch($sformatf("cooked_mode read %h, want %h", prdata, want));
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Echo, backspace, carriage return, newline, Ctrl-D and Ctrl-C in cooked mode
   task automatic test_cooked_editing();
      check_mode_readback();
      send_byte(KEY_BS);
      send_byte(8'h61);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(KEY_CR);
      send_byte(KEY_BS);
      send_byte(KEY_NL);
      send_byte(KEY_EOF);
      send_byte(8'h80);
      send_byte(KEY_EOF);
      send_byte(8'h7F);
      send_byte(KEY_INTR);
      send_byte(KEY_INTR);
      send_byte(KEY_CR);
      send_byte(KEY_EOF);
      wait_line_idle();
   endtask

   // Raw pass-through of every control byte; a pending line survives the mode change
   task automatic test_raw_mode();
      send_byte(8'h41);
      send_byte(8'h42);
      wait_line_idle();
      write_csr(ADDR_COOKED, 32'hFFFF_FFFE);
      check_mode_readback();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(KEY_EOF);
      send_byte(KEY_INTR);
      send_byte(KEY_BS);
      send_byte(KEY_CR);
      send_byte(KEY_NL);
      wait_line_idle();
      write_csr(ADDR_COOKED, 32'h8000_0001);
      check_mode_readback();
      send_byte(KEY_NL);
      wait_line_idle();
   endtask

   // Writes to an unmapped register index leave the mode alone
   task automatic test_spare_register();
      write_csr(ADDR_SPARE, 32'h0000_0000);
      check_mode_readback();
      send_byte(8'h5A);
      send_byte(KEY_NL);
      wait_line_idle();
   endtask

   // Overlong line while the reader holds off: input stalls behind the held echo,
   // the line fills, extra bytes and the newline are dropped, the full line still goes out
   task automatic test_full_line_under_backpressure();
      hold_left = 200;
      for (int i = 0; i < LINE_DEPTH + 2; i++) send_byte(8'h30 + 8'(i));
      send_byte(KEY_NL);
      wait_line_idle();
   endtask

   // Random lines with random edits and terminators, noise, and a raw phase
   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] value;
      int sent;
      int len;
      int pick;
      for (int phase = 0; phase < 5; phase++) begin
         value = $urandom;
         value[0] = (phase != 2);
         write_csr(ADDR_COOKED, value);
         idle_on = (phase == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < 30) begin
            if (!cooked_copy || $urandom_range(0, 4) == 0) begin
               send_byte(8'($urandom_range(0, 255)));
               sent++;
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 80) send_byte(8'($urandom_range(8'h20, 8'hFF)));
                  else if (pick < 88) send_byte(KEY_BS);
                  else if (pick < 92) send_byte(KEY_CR);
                  else send_byte(8'($urandom_range(0, 255)));
               end
               pick = $urandom_range(0, 9);
               if (pick < 6) send_byte(KEY_NL);
               else if (pick < 8) send_byte(KEY_EOF);
               else send_byte(KEY_INTR);
               sent += len + 1;
            end
         end
         wait_line_idle();
      end
   endtask

   // Reader side: long hold-off on request, else random stall bursts while idle_on is set
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (burst_left == 0) begin
            burst_stall = ($urandom_range(0, 2) == 0);
            burst_left = $urandom_range(1, 17);
         end
         rsp_stall <= burst_stall;
         burst_left = burst_left - 1;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result dest %b data %h", rsp_dest,
                                      rsp_data));
         end else begin
            want = due_results.pop_front();
            if (rsp_dest !== want.dest)
               report_mismatch($sformatf("dest %b, want %b", rsp_dest, want.dest));
            if (rsp_data !== want.data)
               report_mismatch($sformatf("data %h, want %h", rsp_data, want.data));
            if (rsp_end_of_file !== want.end_of_file)
               report_mismatch($sformatf("end_of_file %b, want %b", rsp_end_of_file,
                                         want.end_of_file));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   // Watchdog: too many cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_cooked_editing();
      test_raw_mode();
      test_spare_register();
      idle_on = 1'b1;
      test_full_line_under_backpressure();
      test_random_traffic();
      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
